### hdl/lpac_pkg.sv
// Shared types and constants for the LRU page address cache.
// No dependencies.
package lpac_pkg;

  localparam int CAP_W      = 4;
  localparam int IN_PAGE_W  = 16;
  localparam int FRAME_W    = 32;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  // High half of a frame address; the low half carries the page number.
  localparam logic [FRAME_W-IN_PAGE_W-1:0] FRAME_HI = 16'h4FFF;

  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0
  } reg_idx_t;

endpackage

### hdl/lpac_cfg_regs.sv
// APB register block of the LRU page address cache: the capacity register.
// Depends on lpac_pkg.
module lpac_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lpac_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lpac_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lpac_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [lpac_pkg::CAP_W-1:0]        capacity
);
  import lpac_pkg::*;

  logic [CAP_W-1:0] capacity_r;
  logic [CAP_W-1:0] capacity_nxt;
  reg_idx_t         reg_idx;
  logic             wr_en;

  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    capacity_nxt = capacity_r;
    if (wr_en && reg_idx == REG_CAPACITY) begin
      capacity_nxt = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_CAPACITY: prdata = {{(APB_DATA_W-CAP_W){1'b0}}, capacity_r};
      default:      prdata = '0;
    endcase
  end

  assign pready   = 1'b1;
  assign capacity = capacity_r;

endmodule

### hdl/lpac_entry_array.sv
// Tag store, recency ranks and fill count with parallel tag compare and
// an LRU update registered on each valid lookup. Depends on lpac_pkg.
module lpac_entry_array #(
  parameter int ENTRIES   = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  lkp_valid,
  input  logic [PAGE_BITS-1:0]                  lkp_page,
  input  logic [lpac_pkg::CAP_W-1:0]            capacity,
  output logic                                  lkp_hit,
  output logic [$clog2(ENTRIES+1)-1:0]          fill_count
);
  import lpac_pkg::*;

  localparam int FW = $clog2(ENTRIES + 1);
  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [PAGE_BITS-1:0] tag_r   [ENTRIES];
  logic [RW-1:0]        rank_r  [ENTRIES];
  logic [RW-1:0]        rank_nxt[ENTRIES];
  logic [FW-1:0]        fill_r;
  logic [FW-1:0]        fill_nxt;

  logic [FW-1:0]        eff_cap;
  logic [ENTRIES-1:0]   valid;
  logic [ENTRIES-1:0]   match;
  logic [ENTRIES-1:0]   victim;
  logic [ENTRIES-1:0]   sel;
  logic [RW-1:0]        hit_rank;
  logic [FW-1:0]        old_rank;
  logic                 hit;
  logic                 grow;

  always_comb begin
    eff_cap = FW'(capacity);
    if (capacity == '0) begin
      eff_cap = FW'(1);
    end else if (32'(capacity) > 32'(ENTRIES)) begin
      eff_cap = FW'(ENTRIES);
    end
  end

  // Tags are unique among valid entries, so match is one-hot or empty.
  always_comb begin
    hit_rank = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      valid[j]  = 32'(j) < 32'(fill_r);
      match[j]  = valid[j] && (tag_r[j] == lkp_page);
      victim[j] = valid[j] && (FW'(rank_r[j]) == fill_r - FW'(1));
      if (match[j]) begin
        hit_rank = hit_rank | rank_r[j];
      end
    end
    hit  = |match;
    grow = !hit && (fill_r < eff_cap);
    for (int j = 0; j < ENTRIES; j++) begin
      if (hit) begin
        sel[j] = match[j];
      end else if (grow) begin
        sel[j] = 32'(j) == 32'(fill_r);
      end else begin
        sel[j] = victim[j];
      end
    end
    if (hit) begin
      old_rank = FW'(hit_rank);
    end else if (grow) begin
      old_rank = fill_r;
    end else begin
      old_rank = fill_r - FW'(1);
    end
  end

  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      rank_nxt[j] = rank_r[j];
      if (lkp_valid) begin
        if (valid[j] && FW'(rank_r[j]) < old_rank) begin
          rank_nxt[j] = rank_r[j] + RW'(1);
        end
        if (sel[j]) begin
          rank_nxt[j] = '0;
        end
      end
    end
    fill_nxt = fill_r;
    if (lkp_valid && grow) begin
      fill_nxt = fill_r + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        rank_r[j] <= '0;
      end
    end else begin
      fill_r <= fill_nxt;
      for (int j = 0; j < ENTRIES; j++) begin
        rank_r[j] <= rank_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ENTRIES; j++) begin
      if (lkp_valid && !hit && sel[j]) begin
        tag_r[j] <= lkp_page;
      end
    end
  end

  assign lkp_hit    = hit;
  assign fill_count = fill_r;

endmodule

### hdl/lru_page_address_cache.sv
// LRU page address cache top level: input and result registers around the
// entry array, plus the APB capacity register.
// Depends on lpac_pkg, lpac_cfg_regs and lpac_entry_array.
//
// Usage: drive in_page_number and pulse start; a word is taken at every
// edge with start high and busy low. busy is always low, so a lookup may
// be issued in every cycle. Each lookup gives one result word through the input
// register and the result register: out_valid is high for one cycle with
// out_frame_address and out_hit. The receiver cannot stall; results must be taken as they appear.
// Throughput is one lookup per cycle: the tag compare over all entries and
// the recency update happen between the input register
// and the result register, so back-to-back lookups see each other's fills.
// The capacity register (byte address 0, reset 8) limits how many entries
// fill before the least recently used one is replaced; write it only while
// no lookup is in flight. Reset empties the cache and restores capacity.
module lru_page_address_cache #(
  parameter int ENTRIES   = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [lpac_pkg::IN_PAGE_W-1:0]    in_page_number,
  output logic                              out_valid,
  output logic [lpac_pkg::FRAME_W-1:0]      out_frame_address,
  output logic                              out_hit,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lpac_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lpac_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lpac_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import lpac_pkg::*;

  localparam int FW = $clog2(ENTRIES + 1);

  logic                  in_valid_r;
  logic [PAGE_BITS-1:0]  in_page_r;
  logic                  out_valid_r;
  logic [FRAME_W-1:0]    out_addr_r;
  logic                  out_hit_r;
  logic [FRAME_W-1:0]    frame_addr;
  logic [CAP_W-1:0]      capacity;
  logic                  lkp_hit;
  logic [FW-1:0]         fill_count;

  lpac_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  lpac_entry_array #(
    .ENTRIES   (ENTRIES),
    .PAGE_BITS (PAGE_BITS)
  ) u_array (
    .clk        (clk),
    .rst_n      (rst_n),
    .lkp_valid  (in_valid_r),
    .lkp_page   (in_page_r),
    .capacity   (capacity),
    .lkp_hit    (lkp_hit),
    .fill_count (fill_count)
  );

  assign busy       = 1'b0;
  assign frame_addr = {FRAME_HI, IN_PAGE_W'(in_page_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_page_r <= in_page_number[PAGE_BITS-1:0];
    end
    if (in_valid_r) begin
      out_addr_r <= frame_addr;
      out_hit_r  <= lkp_hit;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_address = out_addr_r;
  assign out_hit           = out_hit_r;

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("lookup gave no result");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_count) <= 32'(ENTRIES))
    else $error("fill count beyond entries");

  a_hit_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> fill_count == $past(fill_count))
    else $error("hit changed fill count");

  a_miss_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |->
      (fill_count == $past(fill_count)) || (fill_count == $past(fill_count) + FW'(1)))
    else $error("miss moved fill count by more than one");
`endif

endmodule

### sim/lru_page_address_cache_test.sv
// Testbench for lru_page_address_cache: random lookups and capacity writes
// checked against an LRU predictor kept in the bench.
// Depends on lpac_pkg and the lru_page_address_cache RTL.
module lru_page_address_cache_test;
  import lpac_pkg::*;

  localparam int ENTRIES    = 8;
  localparam int CYCLE_CAP  = 300000;
  localparam int DRAIN_WAIT = 6;
  localparam logic [APB_ADDR_W-1:0] CAP_ADDR    = APB_ADDR_W'(4 * int'(REG_CAPACITY));
  localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = CAP_ADDR + APB_ADDR_W'(4);

  typedef struct {
    logic [FRAME_W-1:0] frame_address;
    logic               hit;
  } lookup_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [IN_PAGE_W-1:0]  in_page_number = '0;
  logic                  out_valid;
  logic [FRAME_W-1:0]    out_frame_address;
  logic                  out_hit;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // predictor state
  logic [IN_PAGE_W-1:0] tag_mem [ENTRIES];
  logic [FRAME_W-1:0]   frame_mem [ENTRIES];
  int                   rank_mem [ENTRIES];
  int                   fill_count = 0;
  logic [CAP_W-1:0]     capacity = CAP_RESET;

  logic [IN_PAGE_W-1:0] pending_pages[$];
  lookup_t              expected_lookups[$];
  int                   words_offered = 0;
  int                   words_taken = 0;
  int                   gap_left = 0;
  bit                   no_gaps = 1'b0;
  int                   err_count = 0;
  int                   cycle_count = 0;

  lru_page_address_cache dut (
    .clk, .rst_n, .start, .busy, .in_page_number,
    .out_valid, .out_frame_address, .out_hit,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void make_recent(int slot, int old_rank);
    for (int j = 0; j < fill_count; j++) begin
      if (rank_mem[j] < old_rank) rank_mem[j]++;
    end
    rank_mem[slot] = 0;
  endfunction

  function automatic lookup_t translate_page(logic [IN_PAGE_W-1:0] page);
    lookup_t res;
    int      lim;
    int      slot;
    bit      found;
    lim = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : int'(capacity));
    slot = 0;
    found = 1'b0;
    for (int j = 0; j < fill_count; j++) begin
      if (!found && tag_mem[j] == page) begin
        found = 1'b1;
        slot = j;
      end
    end
    res.hit = found;
    if (found) begin
      res.frame_address = frame_mem[slot];
      make_recent(slot, rank_mem[slot]);
    end else begin
      res.frame_address = {FRAME_HI, page};
      if (fill_count < lim) begin
        slot = fill_count;
        make_recent(slot, fill_count);
        fill_count++;
      end else begin
        for (int j = 0; j < fill_count; j++) begin
          if (rank_mem[j] == fill_count - 1) slot = j;
        end
        make_recent(slot, rank_mem[slot]);
      end
      tag_mem[slot] = page;
      frame_mem[slot] = res.frame_address;
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // driver: offers one word at a time on start, each held until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && words_taken != words_offered) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_pages.size() > 0) begin
      start <= 1'b1;
      in_page_number <= pending_pages.pop_front();
      words_offered <= words_offered + 1;
      gap_left <= pick_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: checks results, predicts accepted words, tracks capacity writes
  always @(posedge clk) begin
    lookup_t exp_word;
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_n) begin
      if (out_valid) begin
        if (expected_lookups.size() == 0) begin
          $error("unexpected result word: frame_address %h hit %b",
                 out_frame_address, out_hit);
          err_count++;
        end else begin
          exp_word = expected_lookups.pop_front();
          if (out_frame_address !== exp_word.frame_address) begin
            $error("frame_address: expected %h, got %h",
                   exp_word.frame_address, out_frame_address);
            err_count++;
          end
          if (out_hit !== exp_word.hit) begin
            $error("hit: expected %b, got %b", exp_word.hit, out_hit);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_lookups.push_back(translate_page(in_page_number));
        words_taken++;
      end
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
        capacity = pwdata[CAP_W-1:0];
    end
  end

  task automatic cfg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_check_readback();
    logic [APB_DATA_W-1:0] got;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    paddr <= CAP_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    if (got !== APB_DATA_W'(capacity)) begin
      $error("prdata: expected %h, got %h", APB_DATA_W'(capacity), got);
      err_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_pages.size() > 0 || words_taken != words_offered || start
           || expected_lookups.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic random_phase(int n_words);
    logic [IN_PAGE_W-1:0] pool[$];
    int                   pool_size;
    pool_size = $urandom_range(14, 2);
    for (int k = 0; k < pool_size; k++) pool.push_back(IN_PAGE_W'($urandom));
    no_gaps = ($urandom_range(3) == 0);
    for (int k = 0; k < n_words; k++) begin
      if ($urandom_range(99) < 80)
        pending_pages.push_back(pool[$urandom_range(pool_size - 1)]);
      else
        pending_pages.push_back(IN_PAGE_W'($urandom));
    end
    wait_idle();
  endtask

  initial begin
    logic [CAP_W-1:0] cap_plan[$];
    cap_plan = '{4'd2, 4'd0, 4'd15, 4'd5, 4'd1, 4'd8, 4'd9, 4'd3, 4'd7, 4'd4, 4'd6};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, hits, fill past capacity and eviction
    no_gaps = 1'b1;
    pending_pages.push_back('0);
    pending_pages.push_back('0);
    pending_pages.push_back('1);
    pending_pages.push_back('1);
    for (int b = 0; b < IN_PAGE_W; b++) pending_pages.push_back(IN_PAGE_W'(1) << b);
    pending_pages.push_back('0);
    pending_pages.push_back(IN_PAGE_W'(1) << (IN_PAGE_W - 1));
    wait_idle();
    cfg_check_readback();

    // capacity lowered below the fill, then write to an unused address
    cfg_write(CAP_ADDR, APB_DATA_W'(2));
    cfg_write(UNUSED_ADDR, APB_DATA_W'(5));
    cfg_check_readback();
    pending_pages.push_back(IN_PAGE_W'(1) << (IN_PAGE_W - 1));
    pending_pages.push_back(16'h1234);
    pending_pages.push_back(16'h8000);
    pending_pages.push_back(16'h4000);
    wait_idle();

    foreach (cap_plan[i]) begin
      cfg_write(CAP_ADDR, APB_DATA_W'(cap_plan[i]) | ($urandom & 32'hFFFF_FFF0));
      random_phase(125);
    end
    cfg_check_readback();

    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
